// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the knapsack RTL, clocked on clk_i
// and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/knap_pkg.sv -----
// ----------------------------------------------------------------------------
// knap_pkg
// Shared types for the 0/1 knapsack solver: payload structs and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package knap_pkg;

  localparam int unsigned WeightBits = 10;
  localparam int unsigned ValueBits  = 16;
  localparam int unsigned CapBits    = 10;
  localparam int unsigned ResultBits = 32;

  typedef struct packed {
    logic [WeightBits-1:0] item_weight;
    logic [ValueBits-1:0]  item_value;
    logic                  last_item;
  } knap_in_t;

  typedef struct packed {
    logic [ResultBits-1:0] best_value;
    logic                  overflowed;
  } knap_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming item, start the walk at the top entry
    logic issue;    // read entries j and j-w, step j down
    logic ans_rd;   // read the answer entry
    logic ans_ld;   // load the result register, arm the clear sweep
    logic clr_wr;   // zero entry j, step j down
  } knap_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;     // item weight exceeds the table
    logic at_lo;    // j is the lowest entry this item touches
    logic at_zero;  // j is entry zero
    logic last;     // current item closes the set
  } knap_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/knap_dp.sv -----
// ----------------------------------------------------------------------------
// knap_dp
// Datapath: best-value table memory, walk counter, saturating add and max,
// capacity register, sticky saturation flag and result payload register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module knap_dp #(
  parameter int unsigned MAX_CAPACITY = 1023,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned SUM_BITS     = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire knap_pkg::knap_in_t                  in_data_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [knap_pkg::CapBits-1:0]        cfg_data_i,
  input  wire knap_pkg::knap_cmd_t                 cmd_i,
  output knap_pkg::knap_sts_t                      sts_o,
  output knap_pkg::knap_out_t                      out_data_o
);

  localparam int unsigned Depth = MAX_CAPACITY + 1;
  localparam int unsigned AW    = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int unsigned VB    = (VALUE_BITS < knap_pkg::ValueBits) ?
                                  VALUE_BITS : knap_pkg::ValueBits;

  logic [SUM_BITS-1:0] mem [Depth];

  logic [AW-1:0]                     j_q, j_d;
  logic [knap_pkg::WeightBits-1:0]   w_q;
  logic [VB-1:0]                     v_q;
  logic                              last_q;
  logic [knap_pkg::CapBits-1:0]      cap_q;
  logic                              sat_q, sat_d;
  logic                              wr_pend_q;
  logic [AW-1:0]                     wr_addr_q;
  logic [SUM_BITS-1:0]               rd_a_q, rd_b_q;
  knap_pkg::knap_out_t               out_q;

  logic                              fits;
  logic [AW-1:0]                     lo;
  logic [AW-1:0]                     ans_idx;
  logic [AW-1:0]                     addr_a, addr_b;
  logic [SUM_BITS:0]                 sum;
  logic                              carry;
  logic [SUM_BITS-1:0]               cand, upd;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [SUM_BITS-1:0]               wr_data;

  assign fits    = (32'(w_q) <= 32'(MAX_CAPACITY));
  // zero weight still stops at entry one
  assign lo      = (w_q == '0) ? AW'(1) : AW'(w_q);
  assign ans_idx = (32'(cap_q) > 32'(MAX_CAPACITY)) ? AW'(MAX_CAPACITY) : AW'(cap_q);

  assign addr_a = cmd_i.ans_rd ? ans_idx : j_q;
  assign addr_b = j_q - AW'(w_q);

  assign sum   = {1'b0, rd_b_q} + (SUM_BITS+1)'(v_q);
  assign carry = sum[SUM_BITS];
  assign cand  = carry ? '1 : sum[SUM_BITS-1:0];
  assign upd   = (cand > rd_a_q) ? cand : rd_a_q;

  assign wr_en   = wr_pend_q || cmd_i.clr_wr;
  assign wr_addr = cmd_i.clr_wr ? j_q : wr_addr_q;
  assign wr_data = cmd_i.clr_wr ? '0 : upd;

  always_comb begin
    j_d = j_q;
    if (cmd_i.accept || cmd_i.ans_ld) begin
      j_d = AW'(MAX_CAPACITY);
    end else if (cmd_i.issue || cmd_i.clr_wr) begin
      j_d = j_q - AW'(1);
    end
  end

  always_comb begin
    sat_d = sat_q;
    if (cmd_i.ans_ld) begin
      sat_d = 1'b0;
    end else if (wr_pend_q && carry) begin
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q       <= AW'(MAX_CAPACITY);
      cap_q     <= '0;
      sat_q     <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      j_q       <= j_d;
      sat_q     <= sat_d;
      wr_pend_q <= cmd_i.issue;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // table ports: two reads, one write
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue || cmd_i.ans_rd) begin
      rd_a_q <= mem[addr_a];
    end
    if (cmd_i.issue) begin
      rd_b_q <= mem[addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      w_q    <= in_data_i.item_weight;
      v_q    <= in_data_i.item_value[VB-1:0];
      last_q <= in_data_i.last_item;
    end
    if (cmd_i.issue) begin
      wr_addr_q <= j_q;
    end
    if (cmd_i.ans_ld) begin
      out_q.best_value <= knap_pkg::ResultBits'(rd_a_q);
      out_q.overflowed <= sat_q;
    end
  end

  assign sts_o.skip    = !fits;
  assign sts_o.at_lo   = (j_q == lo);
  assign sts_o.at_zero = (j_q == '0);
  assign sts_o.last    = last_q;
  assign out_data_o    = out_q;

  `ASSERT_RST(a_sat_clears_on_load, $fell(sat_q) |-> $past(cmd_i.ans_ld), "saturation flag lost")
  `ASSERT_NEVER(a_write_clash, wr_pend_q && cmd_i.clr_wr, "update and clear write together")

endmodule

`default_nettype wire

// ----- hw/rtl/knap_ctrl.sv -----
// ----------------------------------------------------------------------------
// knap_ctrl
// Controller: sequences item intake, the table walk, answer readout and the
// clear sweep, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module knap_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output knap_pkg::knap_cmd_t       cmd_o,
  input  wire knap_pkg::knap_sts_t  sts_i
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_ANS_RD = 3'd4;
  localparam logic [2:0] ST_ANS_LD = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.at_zero) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts_i.skip) begin
          state_d = sts_i.last ? ST_ANS_RD : ST_IDLE;
        end else begin
          cmd_o.issue = 1'b1;
          if (sts_i.at_lo) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last table write lands in this cycle
        state_d = sts_i.last ? ST_ANS_RD : ST_IDLE;
      end
      ST_ANS_RD: begin
        if (!out_valid_q) begin
          cmd_o.ans_rd = 1'b1;
          state_d      = ST_ANS_LD;
        end
      end
      ST_ANS_LD: begin
        cmd_o.ans_ld = 1'b1;
        state_d      = ST_CLEAR;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ans_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `ASSERT_RST(a_result_from_load, $rose(out_valid_q) |-> $past(state_q) == ST_ANS_LD, "stray result")
  `ASSERT_RST(a_accept_starts_walk, (in_valid_i && in_ready_o) |=> state_q == ST_UPDATE, "walk not started")
  `ASSERT_NEVER(a_no_overwrite, cmd_o.ans_rd && out_valid_q, "answer read while result pending")

endmodule

`default_nettype wire

// ----- hw/rtl/zero_one_knapsack.sv -----
// ----------------------------------------------------------------------------
// zero_one_knapsack
// Streaming 0/1 knapsack solver. Items come in on the in_* channel; after an
// item flagged last_item the best value for the capacity register and the
// saturation flag leave on the out_* channel. cfg_* writes the capacity.
// Each item walks the best-value table from MAX_CAPACITY down to
// max(weight, 1), one entry per cycle through the table memory (two read
// ports, one write port); an item heavier than the table is skipped. The
// next item is taken only once the walk ends. A last item adds an answer
// readout and a sweep that zeroes the table before the next item is taken.
// Reset starts the same sweep; in_ready_o stays low until it ends.
// Capacity writes are always accepted.
// The result sits in an output register; while the receiver stalls the next
// set is still processed, and only its answer readout waits for the
// register to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_one_knapsack #(
  parameter int unsigned MAX_CAPACITY = 1023,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned SUM_BITS     = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire knap_pkg::knap_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output knap_pkg::knap_out_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [knap_pkg::CapBits-1:0]  cfg_data_i
);

  knap_pkg::knap_cmd_t cmd;
  knap_pkg::knap_sts_t sts;

  assign cfg_ready_o = 1'b1;

  knap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  knap_dp #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .VALUE_BITS   (VALUE_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_zero_one_knapsack.sv -----
// ----------------------------------------------------------------------------
// tb_zero_one_knapsack
// Self-checking bench for the streaming 0/1 knapsack solver. A short table
// of directed item sets and capacity writes runs first, then random item
// sets over a range of capacities. A behavioral copy of the best-value
// table predicts each answer, and every result transaction is checked
// field by field against the oldest pending answer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_zero_one_knapsack;

  localparam int MaxCap       = 1023;
  localparam int TargetItems  = 580;
  localparam int QuietAfter   = 500;     // no idling on either side past this count
  localparam int SettleCycles = 1100;    // answer readout plus clearing sweep
  localparam int HoldCycles   = 30000;   // long receiver stall, spans two item sets
  localparam longint Limit    = 10000000; // several times the slowest legal run

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [knap_pkg::CapBits-1:0]    cap;
    logic [knap_pkg::WeightBits-1:0] weight;
    logic [knap_pkg::ValueBits-1:0]  value;
    logic                            last;
    logic                            typed;      // expected answer given in the row
    logic [knap_pkg::ResultBits-1:0] exp_best;
    logic                            exp_ovf;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_ready;
  knap_pkg::knap_in_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  knap_pkg::knap_out_t           out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [knap_pkg::CapBits-1:0]  cfg_data;

  // predictor state
  logic [knap_pkg::ResultBits-1:0] best_by_cap [0:MaxCap];
  bit                              sum_clipped;
  logic [knap_pkg::CapBits-1:0]    capacity_q;

  knap_pkg::knap_out_t pending_answers [$];
  int                  err_cnt;
  int                  items_done;
  bit                  hold_req;
  bit                  tail_quiet;
  knap_pkg::knap_out_t got_ans;
  knap_pkg::knap_out_t want_ans;

  dir_row_t dir_rows [24] = '{
    // capacity 0 from reset: answer entry is entry zero
    '{ROW_ITEM, 10'd0,    10'd3,    16'd10,     1'b1, 1'b1, 32'd0,     1'b0},
    '{ROW_CFG,  10'd1023, 10'd0,    16'd0,      1'b0, 1'b0, 32'd0,     1'b0},
    // zero weight and full weight at the largest value, then full weight at zero
    '{ROW_ITEM, 10'd0,    10'd0,    16'hffff,   1'b1, 1'b1, 32'd65535, 1'b0},
    '{ROW_ITEM, 10'd0,    10'd1023, 16'hffff,   1'b1, 1'b1, 32'd65535, 1'b0},
    '{ROW_ITEM, 10'd0,    10'd1023, 16'h0000,   1'b1, 1'b1, 32'd0,     1'b0},
    // zero weights stack
    '{ROW_ITEM, 10'd0,    10'd0,    16'd1,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd0,    16'd2,      1'b1, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd512,  16'd100,    1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd511,  16'd200,    1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd600,  16'd250,    1'b1, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd1,    16'h5555,   1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd2,    16'haaaa,   1'b1, 1'b0, 32'd0,     1'b0},
    '{ROW_CFG,  10'd1,    10'd0,    16'd0,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd1,    16'd7,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd2,    16'd100,    1'b1, 1'b0, 32'd0,     1'b0},
    '{ROW_CFG,  10'd512,  10'd0,    16'd0,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd512,  16'hffff,   1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd513,  16'hffff,   1'b1, 1'b0, 32'd0,     1'b0},
    '{ROW_CFG,  10'd0,    10'd0,    16'd0,      1'b0, 1'b0, 32'd0,     1'b0},
    // entry zero never gains value, even from a zero weight
    '{ROW_ITEM, 10'd0,    10'd0,    16'd5,      1'b1, 1'b1, 32'd0,     1'b0},
    '{ROW_CFG,  10'd1023, 10'd0,    16'd0,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd1023, 16'd1,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd1022, 16'd2,      1'b0, 1'b0, 32'd0,     1'b0},
    '{ROW_ITEM, 10'd0,    10'd1,    16'd3,      1'b1, 1'b0, 32'd0,     1'b0}
  };

  zero_one_knapsack i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void clear_table();
    for (int j = 0; j <= MaxCap; j++) best_by_cap[j] = '0;
    sum_clipped = 1'b0;
  endfunction

  // one item of the table walk, high capacities first so each item is taken once
  function automatic void fold_item(input knap_pkg::knap_in_t it, output bit has_ans,
                                    output knap_pkg::knap_out_t ans);
    int         w;
    logic [32:0] cand;
    w       = int'(it.item_weight);
    has_ans = 1'b0;
    ans     = '0;
    for (int j = MaxCap; j >= 1 && j >= w; j--) begin
      cand = {1'b0, best_by_cap[j-w]} + 33'(it.item_value);
      if (cand > 33'h0_ffff_ffff) begin
        sum_clipped = 1'b1;
        cand        = 33'h0_ffff_ffff;
      end
      if (cand[31:0] > best_by_cap[j]) best_by_cap[j] = cand[31:0];
    end
    if (it.last_item) begin
      has_ans         = 1'b1;
      ans.best_value  = best_by_cap[capacity_q];
      ans.overflowed  = sum_clipped;
      clear_table();
    end
  endfunction

  task automatic idle_input(input int n);
    @(negedge clk_i);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // offer one item, wait for the transaction, then predict its answer
  task automatic send_item(input knap_pkg::knap_in_t it, input bit typed,
                           input knap_pkg::knap_out_t typed_ans);
    bit                  has_ans;
    knap_pkg::knap_out_t ans;
    if (!tail_quiet && $urandom_range(3) == 0) idle_input($urandom_range(16, 1));
    @(negedge clk_i);
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_done++;
    if (items_done >= QuietAfter) tail_quiet = 1'b1;
    fold_item(it, has_ans, ans);
    if (has_ans) pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [knap_pkg::CapBits-1:0] cap);
    wait_drained();
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = cap;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    capacity_q = cap;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic knap_pkg::knap_in_t rand_item(input bit last);
    knap_pkg::knap_in_t it;
    case ($urandom_range(3))
      0:       it.item_weight = knap_pkg::WeightBits'($urandom_range(15));
      1:       it.item_weight = knap_pkg::WeightBits'($urandom_range(1023, 1000));
      default: it.item_weight = knap_pkg::WeightBits'($urandom_range(1023));
    endcase
    case ($urandom_range(7))
      0:       it.item_value = '0;
      1:       it.item_value = '1;
      default: it.item_value = knap_pkg::ValueBits'($urandom_range(65535));
    endcase
    it.last_item = last;
    return it;
  endfunction

  // stimulus and end of run
  initial begin
    knap_pkg::knap_in_t           it;
    knap_pkg::knap_out_t          ans;
    int                           phase;
    int                           n_sets;
    int                           n_items;
    logic [knap_pkg::CapBits-1:0] cap;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    rst_ni     = 1'b0;
    err_cnt    = 0;
    items_done = 0;
    hold_req   = 1'b0;
    tail_quiet = 1'b0;
    capacity_q = '0;
    clear_table();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_capacity(dir_rows[r].cap);
      end else begin
        it.item_weight = dir_rows[r].weight;
        it.item_value  = dir_rows[r].value;
        it.last_item   = dir_rows[r].last;
        ans.best_value = dir_rows[r].exp_best;
        ans.overflowed = dir_rows[r].exp_ovf;
        send_item(it, dir_rows[r].typed, ans);
      end
    end

    phase = 0;
    while (items_done < TargetItems) begin
      case ($urandom_range(3))
        0:       cap = '0;
        1:       cap = '1;
        2:       cap = knap_pkg::CapBits'($urandom_range(1023));
        default: cap = knap_pkg::CapBits'($urandom_range(31));
      endcase
      if (phase == 0) cap = '1;
      write_capacity(cap);
      // first phase: receiver stalls while several sets are queued behind it
      if (phase == 0) hold_req = 1'b1;
      n_sets = (phase == 0) ? 4 : $urandom_range(4, 1);
      for (int s = 0; s < n_sets; s++) begin
        n_items = $urandom_range(12, 1);
        for (int i = 0; i < n_items; i++) begin
          send_item(rand_item(i == n_items - 1), 1'b0, '0);
        end
      end
      phase++;
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (!tail_quiet && $urandom_range(7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(16, 1)) @(negedge clk_i);
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      got_ans = out_data;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: best %0d ovf %0b",
                                  got_ans.best_value, got_ans.overflowed));
      end else begin
        want_ans = pending_answers.pop_front();
        if (got_ans.best_value !== want_ans.best_value)
          report_mismatch($sformatf("best_value got %0d want %0d",
                                    got_ans.best_value, want_ans.best_value));
        if (got_ans.overflowed !== want_ans.overflowed)
          report_mismatch($sformatf("overflowed got %0b want %0b",
                                    got_ans.overflowed, want_ans.overflowed));
      end
    end
  end

  initial begin
    longint cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < Limit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout with %0d answers pending", pending_answers.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
